[src/tgarc_pkg.sv]
package tgarc_pkg;

   // size limit and derived counter width
   localparam int MAX_DIM = 4096;
   localparam int DIM_W = $clog2(MAX_DIM) + 1;
   localparam int PROD_W = 2 * DIM_W;
   localparam logic signed [16:0] MAX_DIM_S = 17'(MAX_DIM);

   // fixed field widths
   localparam int INDEX_W = 24;
   localparam int IMG_W = 13;
   localparam int HDR_CNT_W = 5;
   localparam int BPP_W = 4;

   // header byte offsets
   localparam logic [HDR_CNT_W-1:0] HDR_TYPE = 5'd2;
   localparam logic [HDR_CNT_W-1:0] HDR_WIDTH_LO = 5'd12;
   localparam logic [HDR_CNT_W-1:0] HDR_WIDTH_HI = 5'd13;
   localparam logic [HDR_CNT_W-1:0] HDR_HEIGHT_LO = 5'd14;
   localparam logic [HDR_CNT_W-1:0] HDR_HEIGHT_HI = 5'd15;
   localparam logic [HDR_CNT_W-1:0] HDR_DEPTH = 5'd16;
   localparam logic [HDR_CNT_W-1:0] HDR_DESC = 5'd17;

   // header values
   localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
   localparam logic [BPP_W-1:0] MIN_BPP = 4'd3;
   localparam logic [BPP_W-1:0] ALPHA_BPP = 4'd4;
   localparam logic [7:0] OPAQUE = 8'd255;
   localparam int TOP_DOWN_BIT = 5;

   typedef enum logic [2:0] {
      KIND_PIXEL = 3'd0,
      KIND_HEADER_OK = 3'd1,
      KIND_BAD_TYPE = 3'd2,
      KIND_BAD_DEPTH = 3'd3,
      KIND_TOO_LARGE = 3'd4
   } kind_type;

   typedef struct packed {
      logic [7:0] file_byte;
      logic first_byte;
   } req_type;

   typedef struct packed {
      kind_type kind;
      logic [INDEX_W-1:0] pixel_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [IMG_W-1:0] image_width;
      logic [IMG_W-1:0] image_height;
      logic last_pixel;
   } rsp_type;

   // image geometry held after the header
   typedef struct packed {
      logic [BPP_W-1:0] bpp;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic top_down;
   } geom_type;

   // header verdict on the last header byte
   typedef struct packed {
      logic done;
      kind_type kind;
      logic start;
      logic [IMG_W-1:0] image_width;
      logic [IMG_W-1:0] image_height;
      logic [INDEX_W-1:0] start_base;
   } hdr_status_type;

   // pixel completion
   typedef struct packed {
      logic done;
      logic last;
      logic [INDEX_W-1:0] pixel_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pix_status_type;

endpackage

[src/tgarc_hdr.sv]
module tgarc_hdr (
   input logic clock,
   input logic reset,
   input logic take,
   input logic first_byte,
   input logic [7:0] file_byte,
   output tgarc_pkg::hdr_status_type status,
   output tgarc_pkg::geom_type geom
);
   import tgarc_pkg::*;

   logic [HDR_CNT_W-1:0] count_ff, count_in, count_cur;
   logic [7:0] data_type_ff, data_type_in;
   logic [7:0] depth_ff, depth_in;
   logic [7:0] desc_ff, desc_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic last_byte;
   logic bad_depth;
   logic too_large;
   logic width_pos;
   logic height_pos;

   // byte position, restarted by first_byte
   assign count_cur = first_byte ? '0 : count_ff;
   assign last_byte = (count_cur == HDR_DESC);

   // capture header fields
   always_comb begin
      count_in = count_ff;
      data_type_in = data_type_ff;
      depth_in = depth_ff;
      desc_in = desc_ff;
      width_in = width_ff;
      height_in = height_ff;
      prod_in = prod_ff;
      if (take) begin
         count_in = last_byte ? '0 : HDR_CNT_W'(count_cur + 1'b1);
         unique case (count_cur)
            HDR_TYPE: data_type_in = file_byte;
            HDR_WIDTH_LO: width_in[7:0] = file_byte;
            HDR_WIDTH_HI: width_in[15:8] = file_byte;
            HDR_HEIGHT_LO: height_in[7:0] = file_byte;
            HDR_HEIGHT_HI: height_in[15:8] = file_byte;
            HDR_DEPTH: begin
               depth_in = file_byte;
               // bottom row start for flipped images, width and height are complete here
               prod_in = PROD_W'(height_ff[DIM_W-1:0] - 1'b1) * PROD_W'(width_ff[DIM_W-1:0]);
            end
            HDR_DESC: desc_in = file_byte;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         data_type_ff <= '0;
         depth_ff <= '0;
         desc_ff <= '0;
         width_ff <= '0;
         height_ff <= '0;
      end else begin
         count_ff <= count_in;
         data_type_ff <= data_type_in;
         depth_ff <= depth_in;
         desc_ff <= desc_in;
         width_ff <= width_in;
         height_ff <= height_in;
      end
      prod_ff <= prod_in;
   end

   // verdict: data type, then depth, then size
   assign bad_depth = depth_ff[7] || (depth_ff[6:3] < MIN_BPP);
   assign too_large = ($signed(width_ff) > MAX_DIM_S) || ($signed(height_ff) > MAX_DIM_S);
   assign width_pos = !width_ff[15] && (width_ff != '0);
   assign height_pos = !height_ff[15] && (height_ff != '0);

   always_comb begin
      status = '0;
      status.done = take && last_byte;
      if (data_type_ff != TYPE_TRUECOLOR) begin
         status.kind = KIND_BAD_TYPE;
      end else if (bad_depth) begin
         status.kind = KIND_BAD_DEPTH;
      end else if (too_large) begin
         status.kind = KIND_TOO_LARGE;
      end else begin
         status.kind = KIND_HEADER_OK;
         status.start = width_pos && height_pos;
         status.image_width = width_pos ? IMG_W'(width_ff) : '0;
         status.image_height = height_pos ? IMG_W'(height_ff) : '0;
      end
      status.start_base = file_byte[TOP_DOWN_BIT] ? '0 : INDEX_W'(prod_ff);
   end

   assign geom.bpp = depth_ff[6:3];
   assign geom.width = width_ff[DIM_W-1:0];
   assign geom.height = height_ff[DIM_W-1:0];
   assign geom.top_down = desc_ff[TOP_DOWN_BIT];

   // an accepted header with pixels always passed the depth check
   a_start_depth : assert property (@(posedge clock) disable iff (reset)
      status.done && status.start |-> geom.bpp >= MIN_BPP && !depth_ff[7])
      else $error("pixel phase started with a bad depth");

   // a header position never passes the descriptor byte
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= HDR_DESC)
      else $error("header position out of range");

   // the last header byte wraps the position back to zero
   a_count_wrap : assert property (@(posedge clock) disable iff (reset)
      status.done |=> count_ff == '0)
      else $error("header position did not wrap");

endmodule

[src/tgarc_pix.sv]
module tgarc_pix (
   input logic clock,
   input logic reset,
   input logic take,
   input logic start,
   input logic [tgarc_pkg::INDEX_W-1:0] start_base,
   input logic [7:0] file_byte,
   input tgarc_pkg::geom_type geom,
   output tgarc_pkg::pix_status_type status
);
   import tgarc_pkg::*;

   logic [BPP_W-1:0] index_ff, index_in;
   logic [2:0][7:0] held_ff, held_in;
   logic [DIM_W-1:0] column_ff, column_in;
   logic [DIM_W-1:0] row_ff, row_in;
   logic [INDEX_W-1:0] row_base_ff, row_base_in;
   logic pixel_done;
   logic row_end;
   logic image_end;

   // pixel completes on its last source byte
   assign pixel_done = (BPP_W'(index_ff + 1'b1) == geom.bpp);
   assign row_end = (column_ff == DIM_W'(geom.width - 1'b1));
   assign image_end = row_end && (row_ff == DIM_W'(geom.height - 1'b1));

   // gather bytes and step the raster position
   always_comb begin
      index_in = index_ff;
      held_in = held_ff;
      column_in = column_ff;
      row_in = row_ff;
      row_base_in = row_base_ff;
      if (start) begin
         index_in = '0;
         column_in = '0;
         row_in = '0;
         row_base_in = start_base;
      end else if (take) begin
         if (index_ff < BPP_W'(3)) begin
            held_in[index_ff[1:0]] = file_byte;
         end
         if (pixel_done) begin
            index_in = '0;
            if (row_end) begin
               column_in = '0;
               row_in = DIM_W'(row_ff + 1'b1);
               row_base_in = geom.top_down ? INDEX_W'(row_base_ff + INDEX_W'(geom.width))
                                           : INDEX_W'(row_base_ff - INDEX_W'(geom.width));
            end else begin
               column_in = DIM_W'(column_ff + 1'b1);
            end
         end else begin
            index_in = BPP_W'(index_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         column_ff <= '0;
         row_ff <= '0;
         row_base_ff <= '0;
      end else begin
         index_ff <= index_in;
         column_ff <= column_in;
         row_ff <= row_in;
         row_base_ff <= row_base_in;
      end
      held_ff <= held_in;
   end

   // colour from the bytes gathered, current byte included
   always_comb begin
      status.done = take && pixel_done;
      status.last = image_end;
      status.pixel_index = INDEX_W'(row_base_ff + INDEX_W'(column_ff));
      status.blue = held_ff[0];
      status.green = held_ff[1];
      status.red = (index_ff == BPP_W'(2)) ? file_byte : held_ff[2];
      status.alpha = (geom.bpp == ALPHA_BPP) ? file_byte : OPAQUE;
   end

   // byte position stays inside the pixel
   a_index_range : assert property (@(posedge clock) disable iff (reset)
      take |-> index_ff < geom.bpp)
      else $error("byte position beyond pixel size");

   // column position stays inside the image width
   a_column_range : assert property (@(posedge clock) disable iff (reset)
      take |-> column_ff < geom.width || geom.width == '0)
      else $error("column beyond image width");

   // a finished row returns the column to zero
   a_row_wrap : assert property (@(posedge clock) disable iff (reset)
      take && pixel_done && row_end && !start |=> column_ff == '0)
      else $error("column not cleared at row end");

endmodule

[src/tga_to_rgba_converter.sv]
// Converts an uncompressed truecolor TGA file, one byte per request, into RGBA pixels.
// A request with first_byte set starts a new file at any point. The 18-byte header
// ends in one verdict (header accepted, bad data type, bad depth, size over limit);
// pixel data is taken to follow the header directly, so ID and colour map fields
// must be absent. Each pixel gives one result with its destination index, rows
// flipped unless descriptor bit 5 is set. One byte is taken every clock when the
// request channel is not stalled; a byte passes an input register and then one
// stage of logic into the result register. A stalled result holds the input register,
// which then stalls the request channel until the result drains.
// Bytes after a verdict that starts no pixels, or after the last pixel, are dropped
// until the next first_byte.
module tga_to_rgba_converter (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input tgarc_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output tgarc_pkg::rsp_type rsp_data
);
   import tgarc_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PIXELS,
      PH_IDLE
   } phase_type;

   phase_type phase_ff, phase_in;
   logic in_valid_ff, in_valid_in;
   req_type in_data_ff, in_data_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic advance;
   logic hdr_take;
   logic pix_take;
   hdr_status_type hdr_st;
   pix_status_type pix_st;
   geom_type geom;

   // handshake: move the held request when the result slot is free or draining
   assign advance = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in = in_data_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_data_in = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_data_ff <= in_data_in;
   end

   // route the byte to header or pixel logic
   assign hdr_take = advance && (in_data_ff.first_byte || phase_ff == PH_HEADER);
   assign pix_take = advance && !in_data_ff.first_byte && phase_ff == PH_PIXELS;

   tgarc_hdr u_hdr (
      .clock(clock),
      .reset(reset),
      .take(hdr_take),
      .first_byte(in_data_ff.first_byte),
      .file_byte(in_data_ff.file_byte),
      .status(hdr_st),
      .geom(geom)
   );

   tgarc_pix u_pix (
      .clock(clock),
      .reset(reset),
      .take(pix_take),
      .start(hdr_st.done && hdr_st.start),
      .start_base(hdr_st.start_base),
      .file_byte(in_data_ff.file_byte),
      .geom(geom),
      .status(pix_st)
   );

   // phase and result slot
   always_comb begin
      phase_in = phase_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      if (hdr_take) begin
         phase_in = PH_HEADER;
         if (hdr_st.done) begin
            phase_in = hdr_st.start ? PH_PIXELS : PH_IDLE;
            rsp_valid_in = 1'b1;
            rsp_data_in = '0;
            rsp_data_in.kind = hdr_st.kind;
            rsp_data_in.image_width = hdr_st.image_width;
            rsp_data_in.image_height = hdr_st.image_height;
         end
      end else if (pix_st.done) begin
         if (pix_st.last) begin
            phase_in = PH_IDLE;
         end
         rsp_valid_in = 1'b1;
         rsp_data_in = '0;
         rsp_data_in.kind = KIND_PIXEL;
         rsp_data_in.pixel_index = pix_st.pixel_index;
         rsp_data_in.red = pix_st.red;
         rsp_data_in.green = pix_st.green;
         rsp_data_in.blue = pix_st.blue;
         rsp_data_in.alpha = pix_st.alpha;
         rsp_data_in.last_pixel = pix_st.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // the last pixel ends the image
   a_last_idle : assert property (@(posedge clock) disable iff (reset)
      pix_st.done && pix_st.last |=> phase_ff == PH_IDLE)
      else $error("phase not idle after last pixel");

   // a header verdict always yields a result
   a_verdict_rsp : assert property (@(posedge clock) disable iff (reset)
      hdr_st.done |=> rsp_valid_ff && rsp_data_ff.kind == hdr_st.kind)
      else $error("header verdict lost");

   // header and pixel logic never finish on the same byte
   a_one_source : assert property (@(posedge clock) disable iff (reset)
      !(hdr_st.done && pix_st.done))
      else $error("two results from one request");

   // a rejected header never enters the pixel phase
   a_reject_idle : assert property (@(posedge clock) disable iff (reset)
      hdr_st.done && hdr_st.kind != KIND_HEADER_OK |=> phase_ff == PH_IDLE)
      else $error("pixel phase after rejected header");

endmodule
